// ===== src/aes_pkg.sv =====
// Shared constants, types and byte-level functions of the AES-128 CBC block.
package aes_pkg;

  localparam int unsigned HalfWidth = 64;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundWidth = 4;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_KEY_HIGH = 3'd0,
    CFG_KEY_LOW  = 3'd1,
    CFG_IV_HIGH  = 3'd2,
    CFG_IV_LOW   = 3'd3,
    CFG_DECRYPT  = 3'd4
  } cfg_index_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic                  load;
    logic                  step;
    logic                  decrypt;
    logic [RoundWidth-1:0] round;
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ===== src/aes128_cbc_block_cipher.sv =====
// AES-128 CBC cipher: from item acceptance to result valid, encrypt runs a load step,
// 10 rounds on one shared round unit, then a step that registers the result.
// Decrypt first runs the 11-step key schedule to capture round keys.
// One item at a time: a new item is accepted only after the result has been taken.
// Synchronous active-high rst clears the sequencer, config registers and chaining value.
module aes128_cbc_block_cipher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [aes_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [aes_pkg::HalfWidth-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [aes_pkg::HalfWidth-1:0]      block_high,
  input  logic [aes_pkg::HalfWidth-1:0]      block_low,
  input  logic                               message_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [aes_pkg::HalfWidth-1:0]      result_high,
  output logic [aes_pkg::HalfWidth-1:0]      result_low
);

  typedef enum logic [2:0] {S_IDLE, S_KEY, S_INIT, S_ROUND, S_DONE} st_t;

  st_t          state;
  logic [3:0]   cnt;
  logic [127:0] key, iv, chain, inblk, res;
  logic         decrypt, cur_dec;
  logic [127:0] rk, rstate, dk;
  logic [127:0] dec_keys [11];
  logic         ks_load, ks_adv;
  aes_pkg::round_ctrl_t ctrl;
  logic [127:0] load_data, chain_use, rkey;

  assign chain_use = chain;

  // Decrypt keys are captured while the schedule runs forward.
  always_ff @(posedge clk) begin
    if (state == S_KEY) dec_keys[cnt] <= rk;
  end

  always_comb begin
    ks_load = (state == S_IDLE) && in_valid;
    ks_adv  = (state == S_KEY) || (state == S_INIT && !cur_dec) ||
              (state == S_ROUND && !cur_dec);
    dk      = dec_keys[4'(aes_pkg::NumRounds) - cnt];
    rkey    = cur_dec ? dk : rk;
    ctrl.load    = (state == S_INIT);
    ctrl.step    = (state == S_ROUND);
    ctrl.decrypt = cur_dec;
    ctrl.round   = cnt;
    load_data = cur_dec ? (inblk ^ dec_keys[4'(aes_pkg::NumRounds)])
                        : (inblk ^ chain_use ^ rk);
  end

  aes_key_sched u_ks (
    .clk(clk), .load(ks_load), .advance(ks_adv), .key(key), .key_out(rk)
  );

  aes_round u_rnd (
    .clk(clk), .ctrl(ctrl), .load_data(load_data), .rkey_in(rkey), .state(rstate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key       <= '0;
      iv        <= '0;
      decrypt   <= 1'b0;
      chain     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      cur_dec   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (aes_pkg::cfg_index_t'(cfg_index))
          aes_pkg::CFG_KEY_HIGH: key[127:64] <= cfg_data;
          aes_pkg::CFG_KEY_LOW:  key[63:0]   <= cfg_data;
          aes_pkg::CFG_IV_HIGH:  iv[127:64]  <= cfg_data;
          aes_pkg::CFG_IV_LOW:   iv[63:0]    <= cfg_data;
          aes_pkg::CFG_DECRYPT:  decrypt     <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            inblk   <= {block_high, block_low};
            cur_dec <= decrypt;
            if (message_start) chain <= iv;
            cnt     <= '0;
            state   <= decrypt ? S_KEY : S_INIT;
          end
        end
        S_KEY: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(aes_pkg::NumRounds)) state <= S_INIT;
        end
        S_INIT: begin
          cnt   <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(aes_pkg::NumRounds)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (cur_dec) begin
              res   <= rstate ^ chain;
              chain <= inblk;
            end else begin
              res   <= rstate;
              chain <= rstate;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign result_high = res[127:64];
  assign result_low  = res[63:0];

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("idle after accept");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (cnt != 4'd0)) else $error("round count zero");
`endif

endmodule

// ===== src/aes_key_sched.sv =====
// Round key generator: steps the AES-128 schedule one round key per cycle while advance is high.
module aes_key_sched (
  input  logic         clk,
  input  logic         load,
  input  logic         advance,
  input  logic [127:0] key,
  output logic [127:0] key_out
);

  logic [127:0] rk;
  logic [7:0]   rcon;
  logic [31:0]  t;
  logic [31:0]  w0, w1, w2, w3;

  always_comb begin
    t  = aes_pkg::sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h0};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rk   <= key;
      rcon <= 8'h01;
    end else if (advance) begin
      rk   <= {w0, w1, w2, w3};
      rcon <= aes_pkg::xtime(rcon);
    end
  end

  assign key_out = rk;

endmodule

// ===== src/aes_round.sv =====
// Shared round unit: one encrypt or decrypt round of the state per cycle while step is set.
module aes_round (
  input  logic                 clk,
  input  aes_pkg::round_ctrl_t ctrl,
  input  logic [127:0]         load_data,
  input  logic [127:0]         rkey_in,
  output logic [127:0]         state
);

  logic [127:0] st;
  logic [127:0] nxt;

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = aes_pkg::xtime(x);
    end
    gm = p;
  endfunction

  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic       last;
    last = (ctrl.round == 4'(aes_pkg::NumRounds));
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.decrypt) t[r + 4*((c + r) & 3)] = aes_pkg::RSBOX[s[r + 4*c]];
        else t[r + 4*c] = aes_pkg::SBOX[s[r + 4*((c + r) & 3)]];
      end
    end
    // Decrypt: add key before inverse mix.
    if (ctrl.decrypt) begin
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ rkey_in[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.decrypt)
          m[4*c+r] = gm(t[4*c+r], 4'he) ^ gm(t[4*c+((r+1)&3)], 4'hb) ^
                     gm(t[4*c+((r+2)&3)], 4'hd) ^ gm(t[4*c+((r+3)&3)], 4'h9);
        else
          m[4*c+r] = gm(t[4*c+r], 4'h2) ^ gm(t[4*c+((r+1)&3)], 4'h3) ^
                     t[4*c+((r+2)&3)] ^ t[4*c+((r+3)&3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last) nxt[127-8*i -: 8] = t[i];
      else if (ctrl.decrypt) nxt[127-8*i -: 8] = m[i];
      else nxt[127-8*i -: 8] = m[i] ^ rkey_in[127-8*i -: 8];
    end
    // Final encrypt round skips mix but still adds the key.
    if (last && !ctrl.decrypt) nxt = nxt ^ rkey_in;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) st <= load_data;
    else if (ctrl.step) st <= nxt;
  end

  assign state = st;

endmodule
